// ===== design/clock_buffer_frame_manager_assert.svh =====
// assertion helpers for the frame manager
`ifndef CLOCK_BUFFER_FRAME_MANAGER_ASSERT_SVH
`define CLOCK_BUFFER_FRAME_MANAGER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CBFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cbfm_pkg.sv =====
package cbfm_pkg;
	localparam int NUM_FRAMES_DEF = 32;
	localparam int PIN_BITS_DEF   = 8;
	localparam int CMD_W    = 3;
	localparam int FILE_W   = 8;
	localparam int PAGE_W   = 32;
	localparam int FRAME_W  = 5;
	localparam int STATUS_W = 4;
	localparam int MAX_ROUNDS = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PIN     = 3'd0,
		CMD_UNPIN   = 3'd1,
		CMD_ALLOC   = 3'd2,
		CMD_DISPOSE = 3'd3,
		CMD_FLUSH   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		RS_HIT        = 4'd0,
		RS_FREE       = 4'd1,
		RS_EVICTED    = 4'd2,
		RS_EXCEEDED   = 4'd3,
		RS_UNPINNED   = 4'd4,
		RS_NOTPINNED  = 4'd5,
		RS_ABSENT     = 4'd6,
		RS_DUPLICATE  = 4'd7,
		RS_DISPOSED   = 4'd8,
		RS_FLUSHWRITE = 4'd9,
		RS_FLUSHPIN   = 4'd10,
		RS_FLUSHDONE  = 4'd11
	} status_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame;
		status_t             status;
		logic                wb_valid;
		logic [FILE_W-1:0]   wb_file;
		logic [PAGE_W-1:0]   wb_page;
		logic                last;
	} result_t;
endpackage

// ===== design/cbfm_req_if.sv =====
interface cbfm_req_if import cbfm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [FILE_W-1:0] file_id;
	logic [PAGE_W-1:0] page_no;
	logic              mark_dirty;

	modport source(output valid, cmd, file_id, page_no, mark_dirty, input ready);
	modport sink(input valid, cmd, file_id, page_no, mark_dirty, output ready);
endinterface

// ===== design/cbfm_rsp_if.sv =====
interface cbfm_rsp_if import cbfm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FRAME_W-1:0]  frame;
	logic [STATUS_W-1:0] status;
	logic                writeback_valid;
	logic [FILE_W-1:0]   writeback_file;
	logic [PAGE_W-1:0]   writeback_page;
	logic                last;

	modport source(output valid, frame, status, writeback_valid, writeback_file,
		writeback_page, last, input ready);
	modport sink(input valid, frame, status, writeback_valid, writeback_file,
		writeback_page, last, output ready);
endinterface

// ===== design/cbfm_out_reg.sv =====
module cbfm_out_reg import cbfm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  result_t     d,
	output logic        room,
	cbfm_rsp_if.source  rsp
);
	logic    full_q;
	result_t data_q;

	// slot frees as the held beat leaves
	assign room = !full_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push) begin
			full_q <= 1'b1;
		end else if (rsp.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= d;
		end
	end

	assign rsp.valid           = full_q;
	assign rsp.frame           = data_q.frame;
	assign rsp.status          = data_q.status;
	assign rsp.writeback_valid = data_q.wb_valid;
	assign rsp.writeback_file  = data_q.wb_file;
	assign rsp.writeback_page  = data_q.wb_page;
	assign rsp.last            = data_q.last;
endmodule

// ===== design/clock_buffer_frame_manager.sv =====
// lookup walks the frame table for pin, unpin, allocate and dispose
// a pin miss or allocate then moves the clock hand frame by frame until it takes a frame or gives up
// flush walks the frames, one beat per dirty frame of the file, plus a done beat; a pinned frame
// of the file ends it early with a pin beat instead; one request at a time, taken only when idle
// reset: valid and reference bits clear at once, hand goes to the last frame, no clearing pass
// result beats sit in an output register; a stalled consumer holds the sequencer at its next beat
module clock_buffer_frame_manager import cbfm_pkg::*; #(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF,
	parameter int PIN_BITS   = PIN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cbfm_req_if.sink   req,
	cbfm_rsp_if.source rsp
);
	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int PW = $clog2(NUM_FRAMES + 1);
	localparam int EW = FILE_W + PAGE_W + 1 + PIN_BITS;
	localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
	localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

	// sequencer states
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOOK  = 7'b0000010,
		S_ACT   = 7'b0000100,
		S_CLK   = 7'b0001000,
		S_FRD   = 7'b0010000,
		S_FEV   = 7'b0100000,
		S_FDONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// frame memory: {file, page, dirty, pin count}, one read port with registered data
	logic [EW-1:0] mem [NUM_FRAMES];
	logic [EW-1:0] mem_rd_q;
	logic [FW-1:0] rd_addr;
	logic          mem_we;
	logic [FW-1:0] mem_wa;
	logic [EW-1:0] mem_wd;

	// per-frame flags kept in flops so reset clears them at once
	logic [NUM_FRAMES-1:0] valid_q, valid_d;
	logic [NUM_FRAMES-1:0] ref_q, ref_d;

	// request captured at accept
	logic [CMD_W-1:0]  cmd_q;
	logic [FILE_W-1:0] file_q;
	logic [PAGE_W-1:0] page_q;
	logic              md_q;

	// walk and clock bookkeeping
	logic [FW-1:0] cnt_q, cnt_d;
	logic [FW-1:0] hand_q, hand_d;
	logic [FW-1:0] start_q, start_d;
	logic [1:0]    rounds_q, rounds_d;
	logic [PW-1:0] pinned_q, pinned_d;
	logic          hit_q, hit_d;
	logic [FW-1:0] hit_idx_q, hit_idx_d;
	logic [EW-1:0] ent_q, ent_d;

	// lookup pipeline: read issued in a cycle, compared in the next
	logic          pend_s1, pend_d;
	logic [FW-1:0] idx_s1;

	// output register
	logic    push;
	logic    room;
	result_t res;

	// fields of the word just read
	logic [FILE_W-1:0]   e_file;
	logic [PAGE_W-1:0]   e_page;
	logic                e_dirty;
	logic [PIN_BITS-1:0] e_pin;
	logic                e_pinned;

	// fields of the entry held from a lookup hit
	logic                h_dirty;
	logic [PIN_BITS-1:0] h_pin;

	// clock step terms
	logic [FW-1:0] nhand;
	logic [PW-1:0] pinned_n;
	logic          clk_found;
	logic          clk_more;
	logic          look_match;

	assign e_file   = mem_rd_q[EW-1 -: FILE_W];
	assign e_page   = mem_rd_q[EW-FILE_W-1 -: PAGE_W];
	assign e_dirty  = mem_rd_q[PIN_BITS];
	assign e_pin    = mem_rd_q[PIN_BITS-1:0];
	assign e_pinned = (e_pin != '0);
	assign h_dirty  = ent_q[PIN_BITS];
	assign h_pin    = ent_q[PIN_BITS-1:0];

	assign req.ready = (state_q == S_IDLE);

	// hand advance wraps at the last frame
	assign nhand     = (hand_q == LAST_FRAME) ? '0 : hand_q + FW'(1);
	assign clk_found = !valid_q[hand_q] || (!ref_q[hand_q] && !e_pinned);
	assign pinned_n  = pinned_q + PW'(e_pinned);
	assign clk_more  = ((start_q != hand_q) || (rounds_q <= 2'(MAX_ROUNDS)))
		&& (pinned_n < PW'(NUM_FRAMES));
	assign look_match = pend_s1 && valid_q[idx_s1]
		&& (e_file == file_q) && (e_page == page_q);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		hand_d    = hand_q;
		start_d   = start_q;
		rounds_d  = rounds_q;
		pinned_d  = pinned_q;
		hit_d     = hit_q;
		hit_idx_d = hit_idx_q;
		ent_d     = ent_q;
		valid_d   = valid_q;
		ref_d     = ref_q;
		pend_d    = 1'b0;
		rd_addr   = (state_q == S_CLK) ? hand_q : cnt_q;
		mem_we    = 1'b0;
		mem_wa    = hit_idx_q;
		mem_wd    = ent_q;
		push      = 1'b0;
		res       = '{frame: '0, status: RS_ABSENT, wb_valid: 1'b0,
			wb_file: '0, wb_page: '0, last: 1'b1};

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cnt_d = '0;
					hit_d = 1'b0;
					case (req.cmd)
						CMD_PIN, CMD_UNPIN, CMD_ALLOC, CMD_DISPOSE: state_d = S_LOOK;
						CMD_FLUSH: state_d = S_FRD;
						default: state_d = S_ACT;
					endcase
				end
			end

			S_LOOK: begin
				// one read issued per cycle, each compared once its registered data returns
				pend_d = 1'b1;
				if (cnt_q != LAST_FRAME) begin
					cnt_d = cnt_q + FW'(1);
				end
				if (look_match) begin
					hit_d     = 1'b1;
					hit_idx_d = idx_s1;
					ent_d     = mem_rd_q;
					pend_d    = 1'b0;
					state_d   = S_ACT;
				end else if (pend_s1 && (idx_s1 == LAST_FRAME)) begin
					pend_d  = 1'b0;
					state_d = S_ACT;
				end
			end

			S_ACT: begin
				res.frame = hit_q ? FRAME_W'(hit_idx_q) : '0;
				case (cmd_q)
					CMD_PIN, CMD_ALLOC: begin
						if (!hit_q) begin
							// miss: start the clock one frame past the hand
							start_d  = hand_q;
							rounds_d = 2'd1;
							pinned_d = '0;
							hand_d   = nhand;
							rd_addr  = nhand;
							state_d  = S_CLK;
						end else if (room) begin
							push = 1'b1;
							state_d = S_IDLE;
							if (cmd_q == CMD_PIN) begin
								res.status = RS_HIT;
								mem_we = 1'b1;
								mem_wd = {ent_q[EW-1:PIN_BITS],
									(h_pin == PIN_MAX) ? h_pin : h_pin + PIN_ONE};
								ref_d[hit_idx_q] = 1'b1;
							end else begin
								res.status = RS_DUPLICATE;
							end
						end
					end
					CMD_UNPIN: begin
						if (room) begin
							push = 1'b1;
							state_d = S_IDLE;
							if (hit_q) begin
								mem_we = 1'b1;
								mem_wd = {ent_q[EW-1:PIN_BITS+1], h_dirty | md_q,
									(h_pin != '0) ? h_pin - PIN_ONE : h_pin};
								res.status = (h_pin != '0) ? RS_UNPINNED : RS_NOTPINNED;
							end
						end
					end
					CMD_DISPOSE: begin
						if (room) begin
							push = 1'b1;
							state_d = S_IDLE;
							if (hit_q) begin
								res.status = RS_DISPOSED;
								valid_d[hit_idx_q] = 1'b0;
								ref_d[hit_idx_q]   = 1'b0;
							end
						end
					end
					default: begin
						if (room) begin
							push = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end

			S_CLK: begin
				if (clk_found) begin
					// take a free frame or evict an unreferenced unpinned one
					res.frame  = FRAME_W'(hand_q);
					res.status = valid_q[hand_q] ? RS_EVICTED : RS_FREE;
					if (valid_q[hand_q] && e_dirty) begin
						res.wb_valid = 1'b1;
						res.wb_file  = e_file;
						res.wb_page  = e_page;
					end
					if (room) begin
						push   = 1'b1;
						mem_we = 1'b1;
						mem_wa = hand_q;
						mem_wd = {file_q, page_q, 1'b0, PIN_ONE};
						valid_d[hand_q] = 1'b1;
						ref_d[hand_q]   = 1'b1;
						state_d = S_IDLE;
					end
				end else if (clk_more) begin
					ref_d[hand_q] = 1'b0;
					// a new sweep starts once the starting frame has been looked at
					if (hand_q == start_q) begin
						rounds_d = rounds_q + 2'd1;
						pinned_d = '0;
					end else begin
						pinned_d = pinned_n;
					end
					hand_d  = nhand;
					rd_addr = nhand;
				end else begin
					// every frame pinned, or out of sweeps
					res.status = RS_EXCEEDED;
					if (room) begin
						push = 1'b1;
						ref_d[hand_q] = 1'b0;
						state_d = S_IDLE;
					end
				end
			end

			S_FRD: begin
				state_d = S_FEV;
			end

			S_FEV: begin
				res.frame = FRAME_W'(cnt_q);
				if (valid_q[cnt_q] && (e_file == file_q) && e_pinned) begin
					res.status = RS_FLUSHPIN;
					if (room) begin
						push = 1'b1;
						state_d = S_IDLE;
					end
				end else if (valid_q[cnt_q] && (e_file == file_q) && e_dirty) begin
					res.status   = RS_FLUSHWRITE;
					res.wb_valid = 1'b1;
					res.wb_file  = e_file;
					res.wb_page  = e_page;
					res.last     = 1'b0;
					if (room) begin
						push = 1'b1;
						valid_d[cnt_q] = 1'b0;
						ref_d[cnt_q]   = 1'b0;
						state_d = (cnt_q == LAST_FRAME) ? S_FDONE : S_FRD;
						cnt_d   = cnt_q + FW'(1);
					end
				end else begin
					if (valid_q[cnt_q] && (e_file == file_q)) begin
						valid_d[cnt_q] = 1'b0;
						ref_d[cnt_q]   = 1'b0;
					end
					state_d = (cnt_q == LAST_FRAME) ? S_FDONE : S_FRD;
					cnt_d   = cnt_q + FW'(1);
				end
			end

			S_FDONE: begin
				res.status = RS_FLUSHDONE;
				if (room) begin
					push = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			ref_q    <= '0;
			hand_q   <= LAST_FRAME;
			cnt_q    <= '0;
			start_q  <= '0;
			rounds_q <= '0;
			pinned_q <= '0;
			hit_q    <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_q  <= valid_d;
			ref_q    <= ref_d;
			hand_q   <= hand_d;
			cnt_q    <= cnt_d;
			start_q  <= start_d;
			rounds_q <= rounds_d;
			pinned_q <= pinned_d;
			hit_q    <= hit_d;
			pend_s1  <= pend_d;
		end
	end

	// payload: request fields, held entry, lookup index
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q  <= req.cmd;
			file_q <= req.file_id;
			page_q <= req.page_no;
			md_q   <= req.mark_dirty;
		end
		hit_idx_q <= hit_idx_d;
		ent_q     <= ent_d;
		idx_s1    <= cnt_q;
	end

	// frame memory; writes only close a request, so reads never race them
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[rd_addr];
	end

	cbfm_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.d      (res),
		.room   (room),
		.rsp    (rsp)
	);

`include "clock_buffer_frame_manager_assert.svh"

	`CBFM_ASSERT_NOW(a_push_room, push, room, "beat pushed into a full output slot")
	`CBFM_ASSERT_NEXT(a_install_valid, (state_q == S_CLK) && clk_found && room,
		valid_q[$past(hand_q)] && ref_q[$past(hand_q)], "installed frame not valid")
	`CBFM_ASSERT_NOW(a_hit_valid, (state_q == S_ACT) && hit_q, valid_q[hit_idx_q],
		"lookup hit names an invalid frame")
	`CBFM_ASSERT_NOW(a_pinned_bound, state_q == S_CLK, pinned_q < PW'(NUM_FRAMES),
		"pinned count ran past the frame count")
endmodule

// ===== sim/tb_clock_buffer_frame_manager.sv =====
`default_nettype none

import cbfm_pkg::*;

// keeps the expected frame table in step with the block and checks its result beats
class frame_table_scoreboard;
	localparam int FRAMES  = NUM_FRAMES_DEF;
	localparam int PIN_TOP = (1 << PIN_BITS_DEF) - 1;

	logic [FILE_W-1:0]       tag_f [FRAMES];
	logic [PAGE_W-1:0]       tag_p [FRAMES];
	bit                      vld   [FRAMES];
	bit                      dirty [FRAMES];
	bit                      refd  [FRAMES];
	int                      pins  [FRAMES];
	int                      hand_pos;
	result_t                 expected_beats[$];
	int                      errors;
	int                      requests;
	int                      beats;
	int                      status_seen[16];

	function new();
		for (int i = 0; i < FRAMES; i++)
			release_frame(i);
		hand_pos = FRAMES - 1;
		errors = 0;
		requests = 0;
		beats = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
	endfunction

	function void release_frame(int i);
		vld[i] = 0;
		dirty[i] = 0;
		refd[i] = 0;
		pins[i] = 0;
		tag_f[i] = '0;
		tag_p[i] = '0;
	endfunction

	function int lookup(logic [FILE_W-1:0] f, logic [PAGE_W-1:0] p);
		for (int i = 0; i < FRAMES; i++)
			if (vld[i] && tag_f[i] == f && tag_p[i] == p)
				return i;
		return -1;
	endfunction

	function void expect_beat(int fr, status_t st, bit wb, logic [FILE_W-1:0] wf,
			logic [PAGE_W-1:0] wp, bit lst);
		result_t r;
		r.frame = fr[FRAME_W-1:0];
		r.status = st;
		r.wb_valid = wb;
		r.wb_file = wb ? wf : '0;
		r.wb_page = wb ? wp : '0;
		r.last = lst;
		expected_beats.push_back(r);
	endfunction

	// clock sweep for a pin miss or an allocate
	function void run_clock(logic [FILE_W-1:0] f, logic [PAGE_W-1:0] p);
		int start_pos;
		int pinned;
		int rounds;
		int fr;
		int h;
		status_t st;
		bit wb;
		logic [FILE_W-1:0] wf;
		logic [PAGE_W-1:0] wp;
		start_pos = hand_pos;
		pinned = 0;
		rounds = 0;
		fr = -1;
		st = RS_FREE;
		wb = 0;
		wf = '0;
		wp = '0;
		do begin
			if (hand_pos == start_pos) begin
				rounds++;
				pinned = 0;
			end
			hand_pos = (hand_pos + 1) % FRAMES;
			h = hand_pos;
			if (!vld[h]) begin
				fr = h;
				st = RS_FREE;
				break;
			end
			if (refd[h]) begin
				refd[h] = 0;
				if (pins[h] > 0)
					pinned++;
				continue;
			end
			if (pins[h] > 0) begin
				pinned++;
				continue;
			end
			fr = h;
			st = RS_EVICTED;
			if (dirty[h]) begin
				wb = 1;
				wf = tag_f[h];
				wp = tag_p[h];
			end
			break;
		end while ((start_pos != hand_pos || rounds <= MAX_ROUNDS) && pinned < FRAMES);

		if (fr < 0) begin
			expect_beat(0, RS_EXCEEDED, 0, '0, '0, 1);
			return;
		end
		release_frame(fr);
		vld[fr] = 1;
		tag_f[fr] = f;
		tag_p[fr] = p;
		pins[fr] = 1;
		refd[fr] = 1;
		expect_beat(fr, st, wb, wf, wp, 1);
	endfunction

	// called once per accepted request beat
	function void note_request(logic [CMD_W-1:0] cmd, logic [FILE_W-1:0] f,
			logic [PAGE_W-1:0] p, logic md);
		int fr;
		requests++;
		fr = lookup(f, p);
		case (cmd)
			CMD_PIN: begin
				if (fr < 0) begin
					run_clock(f, p);
				end else begin
					if (pins[fr] < PIN_TOP)
						pins[fr]++;
					refd[fr] = 1;
					expect_beat(fr, RS_HIT, 0, '0, '0, 1);
				end
			end
			CMD_UNPIN: begin
				if (fr < 0) begin
					expect_beat(0, RS_ABSENT, 0, '0, '0, 1);
				end else begin
					if (md)
						dirty[fr] = 1;
					if (pins[fr] == 0) begin
						expect_beat(fr, RS_NOTPINNED, 0, '0, '0, 1);
					end else begin
						pins[fr]--;
						expect_beat(fr, RS_UNPINNED, 0, '0, '0, 1);
					end
				end
			end
			CMD_ALLOC: begin
				if (fr >= 0)
					expect_beat(fr, RS_DUPLICATE, 0, '0, '0, 1);
				else
					run_clock(f, p);
			end
			CMD_DISPOSE: begin
				if (fr < 0) begin
					expect_beat(0, RS_ABSENT, 0, '0, '0, 1);
				end else begin
					release_frame(fr);
					expect_beat(fr, RS_DISPOSED, 0, '0, '0, 1);
				end
			end
			CMD_FLUSH: begin
				for (int i = 0; i < FRAMES; i++) begin
					if (!vld[i] || tag_f[i] != f)
						continue;
					if (pins[i] != 0) begin
						expect_beat(i, RS_FLUSHPIN, 0, '0, '0, 1);
						return;
					end
					if (dirty[i])
						expect_beat(i, RS_FLUSHWRITE, 1, tag_f[i], tag_p[i], 0);
					release_frame(i);
				end
				expect_beat(0, RS_FLUSHDONE, 0, '0, '0, 1);
			end
			default: expect_beat(0, RS_ABSENT, 0, '0, '0, 1);
		endcase
	endfunction

	// called once per accepted result beat
	function void check_result(result_t got);
		result_t want;
		beats++;
		status_seen[got.status]++;
		if (expected_beats.size() == 0) begin
			$error("result beat with nothing expected: frame %0d status %0d",
				got.frame, got.status);
			errors++;
			return;
		end
		want = expected_beats.pop_front();
		if (got.frame !== want.frame) begin
			$error("frame: expected %0d, got %0d", want.frame, got.frame);
			errors++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.wb_valid !== want.wb_valid) begin
			$error("writeback_valid: expected %0d, got %0d", want.wb_valid, got.wb_valid);
			errors++;
		end
		if (got.wb_file !== want.wb_file) begin
			$error("writeback_file: expected %0h, got %0h", want.wb_file, got.wb_file);
			errors++;
		end
		if (got.wb_page !== want.wb_page) begin
			$error("writeback_page: expected %0h, got %0h", want.wb_page, got.wb_page);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
	endfunction
endclass

module tb_clock_buffer_frame_manager;
	import cbfm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES = NUM_FRAMES_DEF;

	logic clk;
	logic arst_n;

	cbfm_req_if req();
	cbfm_rsp_if rsp();

	clock_buffer_frame_manager u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	frame_table_scoreboard frames_sb;

	// quiet: no idling on either side for the tail of the run
	// hold_req: consumer holds off ready for a long stretch
	bit quiet;
	bit hold_req;

	// 4 ns clock period
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// one request beat; an optional idle gap goes first, valid stays up
	// across back-to-back beats so it is never dropped and raised in one step
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [FILE_W-1:0] f,
			logic [PAGE_W-1:0] p, logic md);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.cmd = cmd;
		req.file_id = f;
		req.page_no = p;
		req.mark_dirty = md;
		req.valid = 1'b1;
		// accept is sampled at the rising edge, ahead of any update from the block
		do @(posedge clk); while (!req.ready);
		frames_sb.note_request(cmd, f, p, md);
	endtask

	// drop valid and wait until every expected beat has come back
	task automatic wait_drained();
		@(negedge clk);
		req.valid = 1'b0;
		while (frames_sb.expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// random page drawn mostly from a small working set so hits and evictions occur
	function automatic logic [PAGE_W-1:0] pick_page();
		if ($urandom_range(0, 15) == 0)
			return $urandom();
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [FILE_W-1:0] pick_file();
		if ($urandom_range(0, 15) == 0)
			return FILE_W'($urandom_range(0, 255));
		return FILE_W'($urandom_range(0, 3));
	endfunction

	// consumer side: random ready bursts, one long hold on request
	initial begin
		int hold;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp.ready = 1'b0;
				// long hold counted here while the producer keeps offering beats
				hold = 0;
				while (hold < 400) begin
					@(negedge clk);
					hold++;
				end
				hold_req = 1'b0;
				rsp.ready = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp.ready = 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				rsp.ready = 1'b1;
			end
		end
	end

	// result beats are sampled at the rising edge
	always @(posedge clk) begin
		result_t got;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready) begin
			got.frame = rsp.frame;
			got.status = status_t'(rsp.status);
			got.wb_valid = rsp.writeback_valid;
			got.wb_file = rsp.writeback_file;
			got.wb_page = rsp.writeback_page;
			got.last = rsp.last;
			frames_sb.check_result(got);
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [CMD_W-1:0] c;
		int r;
		frames_sb = new();
		quiet = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_PIN;
		req.file_id = '0;
		req.page_no = '0;
		req.mark_dirty = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// allocate, then duplicate allocate of the same page
		send_request(CMD_ALLOC, 8'h00, 32'h0, 1'b0);
		send_request(CMD_ALLOC, 8'h00, 32'h0, 1'b0);
		// pin miss at the extreme tag, pin hit, then unpin down past zero
		send_request(CMD_PIN, 8'hff, 32'hffff_ffff, 1'b0);
		send_request(CMD_PIN, 8'hff, 32'hffff_ffff, 1'b0);
		send_request(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1'b1);
		send_request(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1'b0);
		send_request(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1'b1);
		// unpin and dispose of pages not resident
		send_request(CMD_UNPIN, 8'h5a, 32'ha5a5_a5a5, 1'b0);
		send_request(CMD_DISPOSE, 8'h5a, 32'ha5a5_a5a5, 1'b0);
		// dispose of a pinned frame frees it anyway
		send_request(CMD_DISPOSE, 8'h00, 32'h0, 1'b0);
		// unknown command codes
		for (int k = CMD_FLUSH + 1; k < 8; k++) begin
			c = CMD_W'(k);
			send_request(c, 8'h00, 32'h0, 1'b1);
		end
		// flush with a dirty page written back
		send_request(CMD_FLUSH, 8'hff, 32'h0, 1'b0);
		// flush that stops at a pinned frame, then completes after unpin
		send_request(CMD_PIN, 8'h01, 32'h5, 1'b0);
		send_request(CMD_FLUSH, 8'h01, 32'h0, 1'b0);
		send_request(CMD_UNPIN, 8'h01, 32'h5, 1'b1);
		send_request(CMD_FLUSH, 8'h01, 32'h0, 1'b0);

		// every frame pinned, so the sweep gives up
		for (int k = 0; k < FRAMES; k++)
			send_request(CMD_PIN, 8'h03, k, 1'b0);
		send_request(CMD_ALLOC, 8'h03, 32'd100, 1'b0);
		// release them dirty so later evictions carry writebacks
		for (int k = 0; k < FRAMES; k++)
			send_request(CMD_UNPIN, 8'h03, k, 1'b1);

		// producer pause until all results are back
		wait_drained();

		// consumer holds off long while requests keep coming
		hold_req = 1'b1;
		for (int n = 0; n < 70; n++) begin
			if (n == 55)
				quiet = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 35)
				c = CMD_PIN;
			else if (r < 65)
				c = CMD_UNPIN;
			else if (r < 77)
				c = CMD_ALLOC;
			else if (r < 86)
				c = CMD_DISPOSE;
			else if (r < 95)
				c = CMD_FLUSH;
			else
				c = CMD_W'($urandom_range(CMD_FLUSH + 1, 7));
			send_request(c, pick_file(), pick_page(), 1'($urandom_range(0, 1)));
		end

		wait_drained();
		repeat (200) @(posedge clk);

		$display("tb: %0d requests, %0d result beats", frames_sb.requests, frames_sb.beats);
		$display("tb: %0d evictions, %0d exceeded, %0d flush writes",
			frames_sb.status_seen[RS_EVICTED], frames_sb.status_seen[RS_EXCEEDED],
			frames_sb.status_seen[RS_FLUSHWRITE]);
		if (frames_sb.errors == 0 && frames_sb.expected_beats.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

`default_nettype wire
